// ===== rtl/rapc_pkg.sv =====
// Shared constants, types and functions of the antenna phase correction unit.
package rapc_pkg;

  localparam int NumFreqDefault = 2;
  localparam int VarPoints      = 19;
  localparam int CordicSteps    = 20;
  localparam int QueueDepth     = 16;

  localparam logic [4:0] EntryEast  = 5'd19;
  localparam logic [4:0] EntryNorth = 5'd20;
  localparam logic [4:0] EntryUp    = 5'd21;

  localparam logic [1:0] RegAddVar = 2'd0;
  localparam logic [1:0] RegDeltaE = 2'd1;
  localparam logic [1:0] RegDeltaN = 2'd2;
  localparam logic [1:0] RegDeltaU = 2'd3;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [24:0] OutMax = 25'sd16777215;
  localparam logic signed [24:0] OutMin = -25'sd16777216;

  // CORDIC angle state and vector
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [24:0] z;
    logic               flip;
  } cordic_t;

  // item passed from front to back through the queue
  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [16:0] elev;
  } evt_t;

  function automatic logic signed [24:0] atan_step(input logic [4:0] i);
    case (i)
      5'd0:  atan_step = 25'sd2097152;
      5'd1:  atan_step = 25'sd1238021;
      5'd2:  atan_step = 25'sd654136;
      5'd3:  atan_step = 25'sd332050;
      5'd4:  atan_step = 25'sd166669;
      5'd5:  atan_step = 25'sd83416;
      5'd6:  atan_step = 25'sd41718;
      5'd7:  atan_step = 25'sd20860;
      5'd8:  atan_step = 25'sd10430;
      5'd9:  atan_step = 25'sd5215;
      5'd10: atan_step = 25'sd2608;
      5'd11: atan_step = 25'sd1304;
      5'd12: atan_step = 25'sd652;
      5'd13: atan_step = 25'sd326;
      5'd14: atan_step = 25'sd163;
      5'd15: atan_step = 25'sd81;
      5'd16: atan_step = 25'sd41;
      5'd17: atan_step = 25'sd20;
      5'd18: atan_step = 25'sd10;
      5'd19: atan_step = 25'sd5;
      default: atan_step = 25'sd0;
    endcase
  endfunction

  // reduce a binary angle to +-quarter turn, start value of the rotation
  function automatic cordic_t cordic_init(input logic [15:0] ang);
    logic signed [16:0] a;
    cordic_t c;
    a = 17'(signed'(ang));
    c.flip = 1'b0;
    if (a > 17'sd16384) begin
      a = a - 17'sd32768;
      c.flip = 1'b1;
    end else if (a < -17'sd16384) begin
      a = a + 17'sd32768;
      c.flip = 1'b1;
    end
    c.x = CordicGain;
    c.y = '0;
    c.z = 25'(a) <<< 8;
    return c;
  endfunction

  function automatic cordic_t cordic_iter(input cordic_t c, input logic [4:0] i);
    cordic_t n;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    n = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.z[24]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - atan_step(i);
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + atan_step(i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/receiver_antenna_phase_correction_unit.sv =====
// Top level of the receiver antenna phase correction unit.
//
//  channel  | handshake                     | beat
//  in_      | start & !busy                 | req_type, angles, table word
//  out_     | out_strobe, one cycle         | freq_index, range_offset, last
//  cfg_     | cfg_valid & cfg_ready         | cfg_index, cfg_data
//
// An evaluate item gets one result per frequency from the back end, after
// passing the front CORDIC pipeline, the queue and the back-end stages.
// An evaluate item holds a credit from entry to queue pop; busy
// rises at QueueDepth-1 credits, so the back end's one-frequency-per-cycle
// issue sets the rate. A table write waits while any evaluate item is in
// flight; it is written when accepted and gives no result. Reset is synchronous,
// tables are undefined until written; the receiver cannot stall.
module receiver_antenna_phase_correction_unit #(
  parameter int NUM_FREQ = rapc_pkg::NumFreqDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [15:0]        in_azimuth,
  input  logic signed [15:0] in_elevation,
  input  logic               in_table_freq,
  input  logic [4:0]         in_table_entry,
  input  logic signed [23:0] in_table_value,
  output logic               out_strobe,
  output logic               out_freq_index,
  output logic signed [24:0] out_range_offset,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import rapc_pkg::*;

  localparam int AW = $clog2(NUM_FREQ*VarPoints);
  localparam int PipeLen = CordicSteps + 3;
  localparam int CW = $clog2(QueueDepth * NUM_FREQ + PipeLen + 2);

  logic               add_var_r;
  logic signed [23:0] de_r, dn_r, du_r;
  logic               go;
  logic               wr_en, wr_var;
  logic [AW-1:0]      wr_addr;
  logic signed [23:0] wr_data;
  logic               ev_valid, q_valid, q_pop;
  evt_t               ev_data, q_head;
  logic [CW-1:0]      inflight_r;

  assign cfg_ready = 1'b1;
  assign go = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_var_r <= 1'b0;
      de_r <= '0;
      dn_r <= '0;
      du_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegAddVar: add_var_r <= cfg_data[0];
        RegDeltaE: de_r <= signed'(cfg_data);
        RegDeltaN: dn_r <= signed'(cfg_data);
        RegDeltaU: du_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // evaluate items between entry and queue pop; keeps the queue from overflowing
  logic ev_go;
  assign ev_go = go && !in_req_type;
  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_r + CW'(ev_go) - CW'(q_pop);
  end
  // a table write must not overtake evaluate items that still read the tables
  assign busy = (32'(inflight_r) >= QueueDepth - 1) ||
                (in_req_type && inflight_r != '0);

  rapc_front #(.NUM_FREQ(NUM_FREQ)) u_front (
    .clk, .rst_n, .in_go(go), .in_req_type, .in_azimuth, .in_elevation,
    .in_table_freq, .in_table_entry, .in_table_value,
    .wr_en, .wr_var, .wr_addr, .wr_data, .ev_valid, .ev_data
  );

  rapc_queue u_queue (
    .clk, .rst_n, .push(ev_valid), .push_data(ev_data), .pop(q_pop),
    .not_empty(q_valid), .head(q_head)
  );

  rapc_back #(.NUM_FREQ(NUM_FREQ)) u_back (
    .clk, .rst_n, .wr_en, .wr_var, .wr_addr, .wr_data,
    .add_var(add_var_r), .delta_e(de_r), .delta_n(dn_r), .delta_u(du_r),
    .q_valid, .q_head, .q_pop,
    .out_strobe, .out_freq_index, .out_range_offset, .out_last
  );

endmodule

// ===== rtl/rapc_front.sv =====
// Front: accepts items, writes table words, pipelined CORDIC for the unit vector.
module rapc_front #(
  parameter int NUM_FREQ = rapc_pkg::NumFreqDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_go,
  input  logic                 in_req_type,
  input  logic [15:0]          in_azimuth,
  input  logic signed [15:0]   in_elevation,
  input  logic                 in_table_freq,
  input  logic [4:0]           in_table_entry,
  input  logic signed [23:0]   in_table_value,
  output logic                 wr_en,
  output logic                 wr_var,
  output logic [$clog2(NUM_FREQ*rapc_pkg::VarPoints)-1:0] wr_addr,
  output logic signed [23:0]   wr_data,
  output logic                 ev_valid,
  output rapc_pkg::evt_t       ev_data
);
  import rapc_pkg::*;

  localparam int Stages = CordicSteps;
  localparam int AW = $clog2(NUM_FREQ*VarPoints);

  logic               vld_r   [Stages+2];
  cordic_t            az_r    [Stages+1];
  cordic_t            el_r    [Stages+1];
  logic signed [16:0] elev_r  [Stages+2];
  logic signed [31:0] se_r;
  logic signed [63:0] px_r, py_r;
  evt_t               ev_r;
  logic               ev_vld_r;

  logic freq_ok;
  assign freq_ok = 32'(in_table_freq) < NUM_FREQ;

  always_comb begin
    wr_en   = in_go && in_req_type && freq_ok && (in_table_entry <= EntryUp);
    wr_var  = in_table_entry < 5'(VarPoints);
    wr_data = in_table_value;
    if (wr_var)
      wr_addr = AW'(32'(in_table_freq) * VarPoints + 32'(in_table_entry));
    else
      wr_addr = AW'(32'(in_table_freq) * 3 + 32'(in_table_entry - EntryEast));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Stages + 2; i++) vld_r[i] <= 1'b0;
      ev_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_go && !in_req_type;
      for (int i = 1; i < Stages + 2; i++) vld_r[i] <= vld_r[i-1];
      ev_vld_r <= vld_r[Stages+1];
    end
    az_r[0]   <= cordic_init(in_azimuth);
    el_r[0]   <= cordic_init(in_elevation);
    elev_r[0] <= 17'(in_elevation);
    for (int i = 0; i < Stages; i++) begin
      az_r[i+1]   <= cordic_iter(az_r[i], 5'(i));
      el_r[i+1]   <= cordic_iter(el_r[i], 5'(i));
      elev_r[i+1] <= elev_r[i];
    end
    elev_r[Stages+1] <= elev_r[Stages];
    // apply flips and form products
    begin
      logic signed [31:0] ca, sa, ce, se;
      ca = az_r[Stages].flip ? -32'(az_r[Stages].x) : 32'(az_r[Stages].x);
      sa = az_r[Stages].flip ? -32'(az_r[Stages].y) : 32'(az_r[Stages].y);
      ce = el_r[Stages].flip ? -32'(el_r[Stages].x) : 32'(el_r[Stages].x);
      se = el_r[Stages].flip ? -32'(el_r[Stages].y) : 32'(el_r[Stages].y);
      px_r <= 64'(sa) * 64'(ce);
      py_r <= 64'(ca) * 64'(ce);
      se_r <= se;
    end
    ev_r.ex   <= 32'((px_r + 64'sd536870912) >>> 30);
    ev_r.ey   <= 32'((py_r + 64'sd536870912) >>> 30);
    ev_r.ez   <= se_r;
    ev_r.elev <= elev_r[Stages+1];
  end

  assign ev_valid = ev_vld_r;
  assign ev_data  = ev_r;

endmodule

// ===== rtl/rapc_queue.sv =====
// Short queue between front and back.
module rapc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rapc_pkg::evt_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output rapc_pkg::evt_t head
);
  import rapc_pkg::*;

  localparam int PW = $clog2(QueueDepth);

  evt_t        mem_r [QueueDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(push && !pop && cnt_r == (PW+1)'(QueueDepth)))
        else $error("queue overflow");
    end
  end

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) pop |-> not_empty;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_count_move;
    @(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1;
  endproperty
  a_count_move: assert property (p_count_move) else $error("queue count");

  property p_empty_ptrs;
    @(posedge clk) disable iff (!rst_n) cnt_r == '0 |-> wp_r == rp_r;
  endproperty
  a_empty_ptrs: assert property (p_empty_ptrs) else $error("queue pointers");

endmodule

// ===== rtl/rapc_back.sv =====
// Back: per-frequency dot product, variation interpolation, saturation.
module rapc_back #(
  parameter int NUM_FREQ = rapc_pkg::NumFreqDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic                 wr_var,
  input  logic [$clog2(NUM_FREQ*rapc_pkg::VarPoints)-1:0] wr_addr,
  input  logic signed [23:0]   wr_data,
  input  logic                 add_var,
  input  logic signed [23:0]   delta_e,
  input  logic signed [23:0]   delta_n,
  input  logic signed [23:0]   delta_u,
  input  logic                 q_valid,
  input  rapc_pkg::evt_t       q_head,
  output logic                 q_pop,
  output logic                 out_strobe,
  output logic                 out_freq_index,
  output logic signed [24:0]   out_range_offset,
  output logic                 out_last
);
  import rapc_pkg::*;

  localparam int AW = $clog2(NUM_FREQ*VarPoints);
  localparam int FW = (NUM_FREQ > 1) ? $clog2(NUM_FREQ) : 1;
  localparam int OD = NUM_FREQ * 3;
  localparam int OW = $clog2(OD + 1);

  logic signed [23:0] var_mem [NUM_FREQ*VarPoints];
  logic signed [23:0] off_r   [OD];

  logic [FW-1:0] fcnt_r;
  logic          issue;
  assign issue = q_valid;
  assign q_pop = issue && (32'(fcnt_r) == NUM_FREQ - 1);

  // nadir index/weight
  logic signed [24:0] p;
  logic signed [8:0]  idx;
  logic [15:0]        frac;
  logic               clamp;
  logic [4:0]         pt;
  always_comb begin
    p    = (25'sd16384 - 25'(q_head.elev)) * 25'sd72;
    idx  = 9'(p >>> 16);
    frac = p[15:0];
    clamp = 1'b0;
    pt = '0;
    if (idx < 9'sd0) begin
      clamp = 1'b1;
      pt = 5'd0;
    end else if (idx >= 9'(VarPoints - 1)) begin
      clamp = 1'b1;
      pt = 5'(VarPoints - 1);
    end else begin
      pt = 5'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_var) var_mem[wr_addr] <= wr_data;
    if (wr_en && !wr_var) off_r[OW'(wr_addr)] <= wr_data;
  end

  // stage 1 registers
  logic               s1_v_r, s1_last_r, s1_add_r, s1_clamp_r;
  logic [FW-1:0]      s1_f_r;
  logic signed [23:0] s1_v0_r, s1_v1_r;
  logic [15:0]        s1_frac_r;
  logic signed [24:0] s1_se_r, s1_sn_r, s1_su_r;
  logic signed [31:0] s1_ex_r, s1_ey_r, s1_ez_r;
  // stage 2
  logic               s2_v_r, s2_last_r, s2_add_r;
  logic [FW-1:0]      s2_f_r;
  logic signed [57:0] s2_pe_r, s2_pn_r, s2_pu_r;
  logic signed [41:0] s2_va_r, s2_vb_r;
  logic               s2_clamp_r;
  logic signed [23:0] s2_vc_r;
  // stage 3
  logic               s3_v_r, s3_last_r;
  logic [FW-1:0]      s3_f_r;
  logic signed [26:0] s3_r_r;
  logic signed [24:0] out_r;
  logic               out_v_r, out_last_r;
  logic [FW-1:0]      out_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue) fcnt_r <= q_pop ? '0 : fcnt_r + 1'b1;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
    s1_f_r     <= fcnt_r;
    s1_last_r  <= q_pop;
    s1_add_r   <= add_var;
    s1_clamp_r <= clamp;
    s1_v0_r    <= var_mem[AW'(32'(fcnt_r) * VarPoints + 32'(pt))];
    s1_v1_r    <= var_mem[AW'(32'(fcnt_r) * VarPoints + 32'(pt) + (clamp ? 0 : 1))];
    s1_frac_r  <= frac;
    s1_se_r <= 25'(off_r[OW'(32'(fcnt_r) * 3)])     + 25'(delta_e);
    s1_sn_r <= 25'(off_r[OW'(32'(fcnt_r) * 3 + 1)]) + 25'(delta_n);
    s1_su_r <= 25'(off_r[OW'(32'(fcnt_r) * 3 + 2)]) + 25'(delta_u);
    s1_ex_r <= q_head.ex;
    s1_ey_r <= q_head.ey;
    s1_ez_r <= q_head.ez;

    s2_f_r    <= s1_f_r;
    s2_last_r <= s1_last_r;
    s2_add_r  <= s1_add_r;
    s2_clamp_r <= s1_clamp_r;
    s2_vc_r   <= s1_v0_r;
    s2_pe_r <= 58'(s1_se_r) * 58'(s1_ex_r);
    s2_pn_r <= 58'(s1_sn_r) * 58'(s1_ey_r);
    s2_pu_r <= 58'(s1_su_r) * 58'(s1_ez_r);
    s2_va_r <= 42'(s1_v0_r) * 42'(signed'({1'b0, 17'(17'h10000 - 17'(s1_frac_r))}));
    s2_vb_r <= 42'(s1_v1_r) * 42'(signed'({1'b0, s1_frac_r}));

    begin
      logic signed [59:0] acc;
      logic signed [26:0] dot;
      logic signed [42:0] vs;
      logic signed [26:0] vv;
      acc = 60'(s2_pe_r) + 60'(s2_pn_r) + 60'(s2_pu_r) + 60'sd536870912;
      dot = -27'(acc >>> 30);
      vs  = 43'(s2_va_r) + 43'(s2_vb_r) + 43'sd32768;
      vv  = s2_clamp_r ? 27'(s2_vc_r) : 27'(vs >>> 16);
      s3_r_r <= s2_add_r ? dot + vv : dot;
    end
    s3_f_r    <= s2_f_r;
    s3_last_r <= s2_last_r;

    if (s3_r_r > 27'(OutMax))      out_r <= OutMax;
    else if (s3_r_r < 27'(OutMin)) out_r <= OutMin;
    else                           out_r <= 25'(s3_r_r);
    out_f_r    <= s3_f_r;
    out_last_r <= s3_last_r;
  end

  assign out_strobe       = out_v_r;
  assign out_freq_index   = out_f_r[0];
  assign out_range_offset = out_r;
  assign out_last         = out_last_r;

  property p_last_at_end;
    @(posedge clk) disable iff (!rst_n)
      (out_v_r && out_last_r) |-> 32'(out_f_r) == NUM_FREQ - 1;
  endproperty
  a_last_at_end: assert property (p_last_at_end) else $error("last flag misplaced");

  property p_seq;
    @(posedge clk) disable iff (!rst_n)
      (issue && !q_pop) |=> issue && fcnt_r == $past(fcnt_r) + 1'b1;
  endproperty
  a_seq: assert property (p_seq) else $error("frequency sequence broken");

  property p_pop_cnt;
    @(posedge clk) disable iff (!rst_n) q_pop |=> fcnt_r == '0;
  endproperty
  a_pop_cnt: assert property (p_pop_cnt) else $error("count not cleared");

endmodule
